/* src/scdb_pkg.sv */
// ----------------------------------------------------------------------------
// scdb_pkg
// Types, opcode codes and lookup helpers shared by the CDB field decoder.
// ----------------------------------------------------------------------------
package scdb_pkg;

	// Command transaction: one CDB of up to 16 bytes
	typedef struct packed {
		logic [63:0] cdb_head;
		logic [63:0] cdb_tail;
	} cmd_t;

	typedef enum logic [1:0] {
		DIR_NONE     = 2'd0,
		DIR_FROM_DEV = 2'd1,
		DIR_TO_DEV   = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_BAD_GROUP = 2'd1,
		ST_NO_RULE   = 2'd2
	} status_t;

	// Result transaction
	typedef struct packed {
		logic [4:0]  cdb_length;
		logic [63:0] block_address;
		logic [47:0] transfer_bytes;
		dir_t        direction;
		status_t     decode_status;
	} res_t;

	localparam int BS_W  = 17;
	localparam int CNT_W = 32;
	localparam int XFR_W = 48;

	localparam logic [BS_W-1:0] BLOCK_SIZE_RST = 17'd512;
	localparam logic [BS_W-1:0] BLOCK_SIZE_MAX = 17'h10000;

	// Opcode groups (opcode bits 7..5)
	localparam logic [2:0] GRP_6   = 3'd0;
	localparam logic [2:0] GRP_10A = 3'd1;
	localparam logic [2:0] GRP_10B = 3'd2;
	localparam logic [2:0] GRP_16  = 3'd4;
	localparam logic [2:0] GRP_12  = 3'd5;

	localparam logic [4:0] LEN_6  = 5'd6;
	localparam logic [4:0] LEN_10 = 5'd10;
	localparam logic [4:0] LEN_12 = 5'd12;
	localparam logic [4:0] LEN_16 = 5'd16;

	// Opcodes with a transfer rule, plus the two ATA passthrough forms
	localparam logic [7:0] OP_TEST_UNIT_READY = 8'h00;
	localparam logic [7:0] OP_START_STOP      = 8'h1b;
	localparam logic [7:0] OP_VERIFY_10       = 8'h2f;
	localparam logic [7:0] OP_VERIFY_12       = 8'haf;
	localparam logic [7:0] OP_VERIFY_16       = 8'h8f;
	localparam logic [7:0] OP_WRITE_SAME_10   = 8'h41;
	localparam logic [7:0] OP_WRITE_SAME_16   = 8'h93;
	localparam logic [7:0] OP_READ_CAP_10     = 8'h25;
	localparam logic [7:0] OP_READ_6          = 8'h08;
	localparam logic [7:0] OP_WRITE_6         = 8'h0a;
	localparam logic [7:0] OP_READ_10         = 8'h28;
	localparam logic [7:0] OP_READ_12         = 8'ha8;
	localparam logic [7:0] OP_READ_16         = 8'h88;
	localparam logic [7:0] OP_WRITE_10        = 8'h2a;
	localparam logic [7:0] OP_WRITE_12        = 8'haa;
	localparam logic [7:0] OP_WRITE_16        = 8'h8a;
	localparam logic [7:0] OP_WR_VERIFY_10    = 8'h2e;
	localparam logic [7:0] OP_WR_VERIFY_12    = 8'hae;
	localparam logic [7:0] OP_WR_VERIFY_16    = 8'h8e;
	localparam logic [7:0] OP_INQUIRY         = 8'h12;
	localparam logic [7:0] OP_ATA_PT_12       = 8'ha1;
	localparam logic [7:0] OP_ATA_PT_16       = 8'h85;

	localparam logic [XFR_W-1:0] READ_CAP_10_BYTES = 48'd8;
	localparam logic [CNT_W-1:0] SHORT_ZERO_BLOCKS = 32'd256;

	// Opcodes whose data moves towards the device
	function automatic logic to_device_op(input logic [7:0] op);
		logic hit;
		case (op)
			8'h0a, 8'h2a, 8'h2e, 8'haa, 8'hae, 8'h8a, 8'h8e,
			8'h2f, 8'haf, 8'h8f, 8'h18, 8'h3a, 8'h39, 8'h40,
			8'h4c, 8'h15, 8'h55, 8'h1d, 8'h3b, 8'h04, 8'h07,
			8'h31, 8'h30, 8'h32, 8'h3d, 8'h3f, 8'h41, 8'h93,
			8'h42, 8'hb0, 8'hb1, 8'hb2, 8'h38, 8'hb6, 8'h5d,
			8'hbf, 8'h5f, 8'ha4, 8'h24, 8'h1b: hit = 1'b1;
			default:                           hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

/* src/scdb_decode.sv */
// ----------------------------------------------------------------------------
// scdb_decode
// Combinational decode of one CDB: length, LBA, byte count, direction, status.
// ----------------------------------------------------------------------------
module scdb_decode
	import scdb_pkg::*;
(
	input  cmd_t                cmd,
	input  logic [BS_W-1:0]     block_size,
	output res_t                res
);

	logic [7:0]       op;
	logic [2:0]       grp;
	logic [7:0]       b1;
	logic             grp_ok;
	logic [4:0]       len;
	logic [63:0]      lba;
	logic [CNT_W-1:0] cnt;
	logic [CNT_W-1:0] mul_cnt;
	logic             use_mul;
	logic [XFR_W-1:0] fixed_xfer;
	logic [XFR_W-1:0] prod;
	logic [XFR_W-1:0] xfer;
	status_t          status;
	dir_t             dir_data;
	dir_t             dir;

	assign op  = cmd.cdb_head[63:56];
	assign grp = op[7:5];
	assign b1  = cmd.cdb_head[55:48];

	always_comb begin
		grp_ok = 1'b1;
		len    = '0;
		lba    = '0;
		cnt    = '0;
		case (grp)
			GRP_6: begin
				len = LEN_6;
				lba = {43'd0, cmd.cdb_head[52:32]};
				cnt = {24'd0, cmd.cdb_head[31:24]};
			end
			GRP_10A, GRP_10B: begin
				len = LEN_10;
				lba = {32'd0, cmd.cdb_head[47:16]};
				cnt = {16'd0, cmd.cdb_head[7:0], cmd.cdb_tail[63:56]};
			end
			GRP_12: begin
				len = LEN_12;
				lba = {32'd0, cmd.cdb_head[47:16]};
				cnt = {cmd.cdb_head[15:0], cmd.cdb_tail[63:48]};
			end
			GRP_16: begin
				len = LEN_16;
				lba = {cmd.cdb_head[47:0], cmd.cdb_tail[63:48]};
				cnt = cmd.cdb_tail[47:16];
			end
			default: grp_ok = 1'b0;
		endcase
	end

	// Per-opcode transfer rule: either a block count to scale or a fixed length
	always_comb begin
		status     = ST_OK;
		use_mul    = 1'b0;
		mul_cnt    = cnt;
		fixed_xfer = '0;
		case (op)
			OP_TEST_UNIT_READY, OP_START_STOP: fixed_xfer = '0;
			OP_VERIFY_10, OP_VERIFY_12, OP_VERIFY_16: begin
				use_mul = 1'b1;
				if (!b1[1])
					mul_cnt = '0;
				else if (b1[2])
					mul_cnt = CNT_W'(1);
			end
			OP_WRITE_SAME_10, OP_WRITE_SAME_16: begin
				use_mul = 1'b1;
				mul_cnt = b1[0] ? '0 : CNT_W'(1);
			end
			OP_READ_CAP_10: fixed_xfer = READ_CAP_10_BYTES;
			OP_READ_6, OP_WRITE_6: begin
				use_mul = 1'b1;
				if (cnt == '0)
					mul_cnt = SHORT_ZERO_BLOCKS;
			end
			OP_WRITE_10, OP_WR_VERIFY_10, OP_WRITE_12, OP_WR_VERIFY_12,
			OP_WRITE_16, OP_WR_VERIFY_16, OP_READ_10, OP_READ_12, OP_READ_16:
				use_mul = 1'b1;
			OP_INQUIRY: fixed_xfer = {32'd0, cmd.cdb_head[39:24]};
			default: status = ST_NO_RULE;
		endcase
	end

	// A 32-bit count times at most 65536 always fits in 48 bits
	assign prod = XFR_W'(mul_cnt) * XFR_W'(block_size);
	assign xfer = use_mul ? prod : fixed_xfer;

	// ATA passthrough takes its direction from byte 2 bit 3
	always_comb begin
		if (to_device_op(op))
			dir_data = DIR_TO_DEV;
		else if (op == OP_ATA_PT_12 || op == OP_ATA_PT_16)
			dir_data = cmd.cdb_head[43] ? DIR_FROM_DEV : DIR_TO_DEV;
		else
			dir_data = DIR_FROM_DEV;
	end

	always_comb begin
		if (status == ST_NO_RULE)
			dir = dir_data;
		else if (xfer == '0)
			dir = DIR_NONE;
		else
			dir = dir_data;
	end

	always_comb begin
		if (grp_ok) begin
			res.cdb_length     = len;
			res.block_address  = lba;
			res.transfer_bytes = (status == ST_NO_RULE) ? '0 : xfer;
			res.direction      = dir;
			res.decode_status  = status;
		end else begin
			res.cdb_length     = '0;
			res.block_address  = '0;
			res.transfer_bytes = '0;
			res.direction      = DIR_NONE;
			res.decode_status  = ST_BAD_GROUP;
		end
	end

endmodule

/* src/scsi_cdb_field_decoder.sv */
// ----------------------------------------------------------------------------
// scsi_cdb_field_decoder
// Decodes SCSI command descriptor blocks into length, LBA, byte count,
// data direction and status, one transaction per cycle while results are taken.
// ----------------------------------------------------------------------------
// Each CDB transaction is captured in an input register, decoded by one pass
// of field selection, opcode match and a 32x17 multiply, and held in a result
// register, which presents it as a valid result. A new CDB is accepted every
// cycle while results are taken. block_size is written
// through cfg_we/cfg_wdata (reset 512, values above 65536 act as 65536) and
// must only change while no transaction is in flight.
module scsi_cdb_field_decoder
	import scdb_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_stall,
	input  cmd_t            cmd,
	output logic            res_valid,
	input  logic            res_stall,
	output res_t            res,
	input  logic            cfg_we,
	input  logic [BS_W-1:0] cfg_wdata
);

	logic            valid_s1;
	cmd_t            cmd_s1;
	logic            res_valid_q;
	res_t            res_q;
	logic [BS_W-1:0] block_size_q;
	logic [BS_W-1:0] bs_eff;
	logic            adv_out;
	logic            adv_s1;
	res_t            dec_res;

	assign adv_out   = !res_valid_q || !res_stall;
	assign adv_s1    = !valid_s1 || adv_out;
	assign cmd_stall = !adv_s1;

	// Bit 16 set means 65536 or above: clamp to 65536
	assign bs_eff = block_size_q[BS_W-1] ? BLOCK_SIZE_MAX : block_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			block_size_q <= BLOCK_SIZE_RST;
		else if (cfg_we)
			block_size_q <= cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv_s1)
			valid_s1 <= cmd_valid;
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && cmd_valid)
			cmd_s1 <= cmd;
	end

	scdb_decode u_decode (
		.cmd        (cmd_s1),
		.block_size (bs_eff),
		.res        (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			res_valid_q <= 1'b0;
		else if (adv_out)
			res_valid_q <= valid_s1;
	end

	// Hold the result while the downstream side stalls
	always_ff @(posedge clk) begin
		if (adv_out && valid_s1)
			res_q <= dec_res;
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef SYNTHESIS
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (valid_s1 && res_valid_q && res_stall))
		else $error("input stalled while pipeline has room");

	a_accept_reaches_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && !cmd_stall) |=> valid_s1)
		else $error("accepted transaction lost before decode");

	a_bad_group_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.decode_status == ST_BAD_GROUP) |->
		(res.cdb_length == 5'd0 && res.transfer_bytes == '0 && res.direction == DIR_NONE))
		else $error("invalid group result carries data");

	a_zero_xfer_no_dir: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res.decode_status == ST_OK && res.transfer_bytes == '0) |->
		(res.direction == DIR_NONE))
		else $error("zero-length transfer with a direction");
`endif

endmodule

/* verif/scsi_cdb_field_decoder_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scsi_cdb_field_decoder_tb
// Self-checking bench for the CDB field decoder. A directed set of command
// blocks is followed by random phases under several block sizes and idling
// patterns. Each accepted CDB is decoded by a local predictor, and the
// decoder's result is compared field by field, in order.
// ----------------------------------------------------------------------------
module scsi_cdb_field_decoder_tb;
	import scdb_pkg::*;

	localparam int ITEMS_PER_PHASE = 240;
	localparam int N_PHASES        = 5;
	localparam int LONG_HOLD       = 200;
	localparam int MAX_PRINTS      = 20;

	// Opcodes with a transfer rule, plus the two ATA passthrough forms
	localparam int N_RULE_OPS = 22;
	localparam logic [N_RULE_OPS*8-1:0] RULE_OPS = {
		OP_TEST_UNIT_READY, OP_START_STOP, OP_VERIFY_10, OP_VERIFY_12,
		OP_VERIFY_16, OP_WRITE_SAME_10, OP_WRITE_SAME_16, OP_READ_CAP_10,
		OP_READ_6, OP_WRITE_6, OP_READ_10, OP_READ_12, OP_READ_16,
		OP_WRITE_10, OP_WRITE_12, OP_WRITE_16, OP_WR_VERIFY_10,
		OP_WR_VERIFY_12, OP_WR_VERIFY_16, OP_INQUIRY, OP_ATA_PT_12,
		OP_ATA_PT_16
	};

	// Opcodes whose data moves towards the device
	localparam int N_TO_DEV = 40;
	localparam logic [N_TO_DEV*8-1:0] TO_DEV_OPS = {
		8'h0a, 8'h2a, 8'h2e, 8'haa, 8'hae, 8'h8a, 8'h8e,
		8'h2f, 8'haf, 8'h8f, 8'h18, 8'h3a, 8'h39, 8'h40,
		8'h4c, 8'h15, 8'h55, 8'h1d, 8'h3b, 8'h04, 8'h07,
		8'h31, 8'h30, 8'h32, 8'h3d, 8'h3f, 8'h41, 8'h93,
		8'h42, 8'hb0, 8'hb1, 8'hb2, 8'h38, 8'hb6, 8'h5d,
		8'hbf, 8'h5f, 8'ha4, 8'h24, 8'h1b
	};

	logic            clk       = 1'b0;
	logic            arst_n    = 1'b0;
	logic            cmd_valid = 1'b0;
	logic            cmd_stall;
	cmd_t            cmd       = '0;
	logic            res_valid;
	logic            res_stall = 1'b0;
	res_t            res;
	logic            cfg_we    = 1'b0;
	logic [BS_W-1:0] cfg_wdata = '0;

	cmd_t            cdb_backlog[$];
	res_t            decoded_due[$];
	logic [BS_W-1:0] blk_size   = BLOCK_SIZE_RST;
	logic            cmd_taken  = 1'b0;
	int              send_idle_pct  = 0;
	int              recv_stall_pct = 0;
	logic            long_hold_req  = 1'b0;
	int              hold_left      = 0;
	int              errors     = 0;
	int              n_cdbs     = 0;
	int              n_results  = 0;
	int              n_held     = 0;
	int              n_settings = 0;

	scsi_cdb_field_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always #1 clk = ~clk;

	function automatic res_t decode_cdb(input cmd_t c, input logic [BS_W-1:0] bsz);
		logic [7:0]  b [16];
		logic [7:0]  op;
		logic [63:0] cnt;
		logic [63:0] bs;
		logic [63:0] xfer;
		logic        no_rule;
		logic        to_dev;
		res_t        r;
		for (int i = 0; i < 8; i++) begin
			b[i]     = c.cdb_head[63-8*i -: 8];
			b[i + 8] = c.cdb_tail[63-8*i -: 8];
		end
		op      = b[0];
		r       = '0;
		xfer    = '0;
		no_rule = 1'b0;
		bs      = (bsz > BLOCK_SIZE_MAX) ? 64'(BLOCK_SIZE_MAX) : 64'(bsz);

		case (op[7:5])
			GRP_6: begin
				r.cdb_length    = LEN_6;
				r.block_address = {43'd0, b[1][4:0], b[2], b[3]};
				cnt             = 64'(b[4]);
			end
			GRP_10A, GRP_10B: begin
				r.cdb_length    = LEN_10;
				r.block_address = {32'd0, b[2], b[3], b[4], b[5]};
				cnt             = {48'd0, b[7], b[8]};
			end
			GRP_12: begin
				r.cdb_length    = LEN_12;
				r.block_address = {32'd0, b[2], b[3], b[4], b[5]};
				cnt             = {32'd0, b[6], b[7], b[8], b[9]};
			end
			GRP_16: begin
				r.cdb_length    = LEN_16;
				r.block_address = {b[2], b[3], b[4], b[5], b[6], b[7], b[8], b[9]};
				cnt             = {32'd0, b[10], b[11], b[12], b[13]};
			end
			default: begin
				r.decode_status = ST_BAD_GROUP;
				return r;
			end
		endcase

		case (op)
			OP_TEST_UNIT_READY, OP_START_STOP: xfer = '0;
			OP_VERIFY_10, OP_VERIFY_12, OP_VERIFY_16: begin
				// BYTCHK clear moves nothing; bit 2 set checks a single block
				if (!b[1][1])
					cnt = '0;
				else if (b[1][2])
					cnt = 64'd1;
				xfer = cnt * bs;
			end
			OP_WRITE_SAME_10, OP_WRITE_SAME_16: xfer = b[1][0] ? 64'd0 : bs;
			OP_READ_CAP_10: xfer = 64'(READ_CAP_10_BYTES);
			OP_READ_6, OP_WRITE_6: begin
				if (cnt == 0)
					cnt = 64'(SHORT_ZERO_BLOCKS);
				xfer = cnt * bs;
			end
			OP_READ_10, OP_READ_12, OP_READ_16, OP_WRITE_10, OP_WRITE_12, OP_WRITE_16,
			OP_WR_VERIFY_10, OP_WR_VERIFY_12, OP_WR_VERIFY_16: xfer = cnt * bs;
			OP_INQUIRY: xfer = {48'd0, b[3], b[4]};
			default: no_rule = 1'b1;
		endcase

		to_dev = 1'b0;
		for (int k = 0; k < N_TO_DEV; k++)
			if (TO_DEV_OPS[8*k +: 8] == op)
				to_dev = 1'b1;

		// an opcode without a rule still reports a direction as if data moved
		if (!no_rule && xfer == 0)
			r.direction = DIR_NONE;
		else if (to_dev)
			r.direction = DIR_TO_DEV;
		else if ((op == OP_ATA_PT_12 || op == OP_ATA_PT_16) && !b[2][3])
			r.direction = DIR_TO_DEV;
		else
			r.direction = DIR_FROM_DEV;

		if (no_rule)
			r.decode_status = ST_NO_RULE;
		else
			r.decode_status = ST_OK;
		r.transfer_bytes = xfer[47:0];
		return r;
	endfunction

	// Mostly opcodes with a rule, some to-device ones, the rest any byte
	function automatic cmd_t random_cdb();
		cmd_t c;
		int   sel;
		int   idx;
		c.cdb_head = {$urandom, $urandom};
		c.cdb_tail = {$urandom, $urandom};
		case ($urandom_range(7))
			0: begin
				c.cdb_head = '0;
				c.cdb_tail = '0;
			end
			1: begin
				c.cdb_head = '1;
				c.cdb_tail = '1;
			end
			// clear bytes 4 to 13, which holds the count of every group
			2: begin
				c.cdb_head[31:0]  = '0;
				c.cdb_tail[63:16] = '0;
			end
			default: ;
		endcase
		sel = $urandom_range(9);
		if (sel < 6) begin
			idx = $urandom_range(N_RULE_OPS - 1);
			c.cdb_head[63:56] = RULE_OPS[8*idx +: 8];
		end else if (sel < 8) begin
			idx = $urandom_range(N_TO_DEV - 1);
			c.cdb_head[63:56] = TO_DEV_OPS[8*idx +: 8];
		end else begin
			c.cdb_head[63:56] = 8'($urandom);
		end
		return c;
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		errors++;
		if (errors <= MAX_PRINTS)
			$display("%0t: %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
	endtask

	task automatic wait_idle();
		int quiet;
		quiet = 0;
		// Wait for a quiet edge to repeat: the driver may pick up a transaction at the same edge
		while (quiet < 2) begin
			@(negedge clk);
			if (cdb_backlog.size() != 0 || cmd_valid || decoded_due.size() != 0)
				quiet = 0;
			else
				quiet++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_block_size(input logic [BS_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		n_settings++;
	endtask

	// Command driver: advance to the next CDB once the current one is taken
	always @(negedge clk) begin
		if (!cmd_valid || cmd_taken) begin
			if (cdb_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				cmd       <= cdb_backlog.pop_front();
				cmd_valid <= 1'b1;
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// Result receiver: random stalls, or one long hold when asked
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left <= hold_left - 1;
			res_stall <= 1'b1;
		end else if (long_hold_req) begin
			long_hold_req = 1'b0;
			hold_left <= LONG_HOLD;
			res_stall <= 1'b1;
		end else begin
			res_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	// Monitor: predict on accepted commands, check accepted results
	always @(posedge clk) begin
		res_t want;
		cmd_taken = arst_n && cmd_valid && !cmd_stall;
		if (arst_n && cfg_we)
			blk_size = cfg_wdata;
		if (arst_n && cmd_valid && cmd_stall)
			n_held++;
		if (cmd_taken) begin
			decoded_due.push_back(decode_cdb(cmd, blk_size));
			n_cdbs++;
		end
		if (arst_n && res_valid && !res_stall) begin
			if (decoded_due.size() == 0) begin
				report_mismatch("result with nothing outstanding", res.block_address, '0);
			end else begin
				want = decoded_due.pop_front();
				n_results++;
				if (res.cdb_length !== want.cdb_length)
					report_mismatch("cdb_length", 64'(res.cdb_length),
						64'(want.cdb_length));
				if (res.block_address !== want.block_address)
					report_mismatch("block_address", res.block_address, want.block_address);
				if (res.transfer_bytes !== want.transfer_bytes)
					report_mismatch("transfer_bytes", 64'(res.transfer_bytes),
						64'(want.transfer_bytes));
				if (res.direction !== want.direction)
					report_mismatch("direction", 64'(res.direction), 64'(want.direction));
				if (res.decode_status !== want.decode_status)
					report_mismatch("decode_status", 64'(res.decode_status),
						64'(want.decode_status));
			end
		end
	end

	initial begin
		cmd_t            c;
		int              n_directed;
		logic [BS_W-1:0] cfg_vals [N_PHASES];
		int              send_modes [N_PHASES];
		int              recv_modes [N_PHASES];

		cfg_vals   = '{17'd1, 17'h1ffff, 17'd0, BLOCK_SIZE_MAX,
			17'($urandom_range(65536, 1))};
		send_modes = '{0, 66, 0, 33, 0};
		recv_modes = '{0, 0, 66, 33, 0};

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed set at the reset block size: every rule opcode with all
		// other bytes set, then a six-byte read of zero blocks, an ATA
		// passthrough towards the device and an invalid group
		for (int k = 0; k < N_RULE_OPS; k++) begin
			c.cdb_head = '1;
			c.cdb_tail = '1;
			c.cdb_head[63:56] = RULE_OPS[8*k +: 8];
			cdb_backlog.push_back(c);
		end
		c = '0;
		c.cdb_head[63:56] = OP_READ_6;
		cdb_backlog.push_back(c);
		c.cdb_head[63:56] = OP_ATA_PT_16;
		cdb_backlog.push_back(c);
		c = '1;
		cdb_backlog.push_back(c);
		n_directed = cdb_backlog.size();
		wait_idle();

		for (int p = 0; p < N_PHASES; p++) begin
			write_block_size(cfg_vals[p]);
			send_idle_pct  = send_modes[p];
			recv_stall_pct = recv_modes[p];
			// hold the receiver off while the sender keeps offering, to fill the block
			if (p == 0)
				long_hold_req = 1'b1;
			repeat (ITEMS_PER_PHASE / 2) cdb_backlog.push_back(random_cdb());
			// drain fully before the second half
			wait_idle();
			repeat (ITEMS_PER_PHASE / 2) cdb_backlog.push_back(random_cdb());
			wait_idle();
		end

		if (decoded_due.size() != 0)
			report_mismatch("results never delivered", 64'(decoded_due.size()), '0);
		$display("Decoded %0d CDBs (%0d directed) across %0d block size settings.",
			n_cdbs, n_directed, n_settings);
		$display("Checked %0d results; command input held off for %0d cycles.",
			n_results, n_held);
		if (errors == 0)
			$display("scsi_cdb_field_decoder regression: pass");
		else
			$display("scsi_cdb_field_decoder regression: fail");
		$finish;
	end

	initial begin
		#1000000;
		$display("scsi_cdb_field_decoder regression: fail");
		$finish;
	end

endmodule
